// ----- sv/two_level_page_table_grow_shrink_top_defines.svh -----
// Assertion macros for the page table frame allocator.
`ifndef TWO_LEVEL_PAGE_TABLE_GROW_SHRINK_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_GROW_SHRINK_TOP_DEFINES_SVH
`ifndef SYNTH
`define TLPT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLPT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLPT_ASSERT(name, clk, rst_n, prop, msg)
`define TLPT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- sv/tlpt_pkg.sv -----
// Shared types and constants of the page table frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;
  localparam int unsigned FRAMES     = 256;
  localparam int unsigned FRAME_W    = 8;
  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned ADDR_W     = FRAME_W + IDX_W;
  localparam int unsigned ENTRY_W    = FRAME_W + 1;
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned FREE_W     = 9;
  localparam int unsigned OPER_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned RADDR_W    = 20;
  localparam int unsigned PAGE_SHIFT = 12;

  typedef enum logic [OPER_W-1:0] {
    OP_CREATE, OP_GROW, OP_SHRINK, OP_FREE
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK, ST_NOFREE, ST_LIMIT, ST_EMPTY
  } status_e;

  typedef enum logic [4:0] {
    DC_NONE, DC_LOAD, DC_SCAN_ROOT, DC_SCAN_SUB, DC_SCAN_RD, DC_SCAN_CHK,
    DC_SET_LAST, DC_NEWTBL_FIRST, DC_NEWTBL_NEXT, DC_SET_F, DC_SET_FM1,
    DC_ST_NOFREE, DC_ST_LIMIT, DC_ST_EMPTY, DC_TAKE_START, DC_TAKE_SUB,
    DC_TAKE_PAGE, DC_CLR_START, DC_CLR_WR, DC_WR_ROOT_SUB, DC_WR_SUB_PAGE,
    DC_ZERO_SUB_ENTRY, DC_ZERO_ROOT_LAST, DC_REL_HIT, DC_REL_SUB,
    DC_FREE_ROOT, DC_DONE
  } dp_cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_FR_CHK, S_S1_RD, S_S1_CHK, S_S1_END, S_S2_START,
    S_S2_RD, S_S2_CHK, S_S2_END, S_CHKFREE, S_TK_SUB, S_CLR_INIT, S_CLR,
    S_G_ROOT, S_G_TAKE2, S_TK_PAGE, S_WR_PAGE, S_SH_REL, S_SH_ZERO,
    S_SH_REL2, S_ZROOT, S_DONE
  } ctrl_state_e;

  typedef struct packed {
    op_e  op;
    logic newtbl;
    logic scan_end;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_last;
    logic last_max;
    logic f_zero;
    logic free_ok;
    logic bm_used;
    logic out_free;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- sv/tlpt_if.sv -----
// Word channel interfaces of the page table frame allocator.
`timescale 1ns / 1ps
`default_nettype none
interface tlpt_in_if
  import tlpt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OPER_W-1:0]  operation;
  logic [RADDR_W-1:0] root_address;
  modport source (output valid, operation, root_address, input ready);
  modport sink (input valid, operation, root_address, output ready);
endinterface

interface tlpt_out_if
  import tlpt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [RADDR_W-1:0] page_address;
  logic [FREE_W-1:0]  free_frames;
  modport source (output valid, status, page_address, free_frames, input ready);
  modport sink (input valid, status, page_address, free_frames, output ready);
endinterface

interface tlpt_cfg_if
  import tlpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FREE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/tlpt_dp.sv -----
// Datapath: table memory, frame bitmap, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_dp
  import tlpt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_e            cmd_i,
  output dp_stat_t                st_o,
  input  wire logic [OPER_W-1:0]  operation_i,
  input  wire logic [RADDR_W-1:0] root_address_i,
  input  wire logic               cfg_we_i,
  input  wire logic [FREE_W-1:0]  cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [RADDR_W-1:0]      page_address_o,
  output logic [FREE_W-1:0]       free_frames_o
);
  logic [ENTRY_W-1:0] mem_q [0:FRAMES*ENTRIES-1];
  logic [ENTRY_W-1:0] rdata_q;

  logic [FREE_W-1:0]  free_q, free_d;
  logic [FRAMES-1:0]  used_q, used_d;
  logic               out_valid_q;

  op_e                op_q;
  logic [FRAME_W-1:0] root_q, tbl_q, hit_q, sub_q, page_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   last_q, f_q;
  status_e            status_q;
  logic               newtbl_q;
  status_e            out_status_q;
  logic [FRAME_W-1:0] out_page_q;
  logic [FREE_W-1:0]  out_free_q;

  logic [FRAME_W-1:0] bm_idx;
  logic               bm_bit;
  logic [ADDR_W-1:0]  maddr;
  logic               mwe;
  logic [ENTRY_W-1:0] mwdata;
  logic [FREE_W-1:0]  cfg_lim;
  logic               cnt_last;

  assign cnt_last = (cnt_q[IDX_W-1:0] == IDX_W'(ENTRIES - 1));
  assign cfg_lim  = (cfg_data_i > FREE_W'(FRAMES)) ? FREE_W'(FRAMES) : cfg_data_i;

  always_comb begin
    case (cmd_i)
      DC_TAKE_SUB, DC_TAKE_PAGE: bm_idx = cnt_q[FRAME_W-1:0];
      DC_REL_HIT:                bm_idx = hit_q;
      DC_REL_SUB:                bm_idx = sub_q;
      default:                   bm_idx = root_q;
    endcase
  end
  assign bm_bit = used_q[bm_idx];

  always_comb begin
    mwe    = 1'b0;
    mwdata = '0;
    case (cmd_i)
      DC_SCAN_RD:        maddr = {tbl_q, cnt_q[IDX_W-1:0]};
      DC_CLR_WR: begin
        maddr = {tbl_q, cnt_q[IDX_W-1:0]};
        mwe   = 1'b1;
      end
      DC_WR_ROOT_SUB: begin
        maddr  = {root_q, last_q};
        mwe    = 1'b1;
        mwdata = {sub_q, 1'b1};
      end
      DC_ZERO_ROOT_LAST: begin
        maddr = {root_q, last_q};
        mwe   = 1'b1;
      end
      DC_WR_SUB_PAGE: begin
        maddr  = {sub_q, f_q};
        mwe    = 1'b1;
        mwdata = {page_q, 1'b1};
      end
      DC_ZERO_SUB_ENTRY: begin
        maddr = {sub_q, f_q};
        mwe   = 1'b1;
      end
      default:           maddr = {tbl_q, cnt_q[IDX_W-1:0]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mem_q[maddr] <= mwdata;
    end
    if (cmd_i == DC_SCAN_RD) begin
      rdata_q <= mem_q[maddr];
    end
  end

  always_comb begin
    used_d = used_q;
    free_d = free_q;
    case (cmd_i)
      DC_TAKE_SUB, DC_TAKE_PAGE: begin
        if (!bm_bit) begin
          used_d[bm_idx] = 1'b1;
          if (free_q != '0) free_d = free_q - 1'b1;
        end
      end
      DC_REL_HIT, DC_REL_SUB, DC_FREE_ROOT: begin
        if (bm_bit) begin
          used_d[bm_idx] = 1'b0;
          if (free_q < FREE_W'(FRAMES)) free_d = free_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      used_d = '0;
      free_d = cfg_lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      free_q      <= FREE_W'(FRAMES);
      out_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      free_q <= free_d;
      if (cmd_i == DC_DONE) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      DC_LOAD: begin
        op_q     <= op_e'(operation_i);
        root_q   <= root_address_i[PAGE_SHIFT +: FRAME_W];
        status_q <= ST_OK;
        page_q   <= '0;
        newtbl_q <= 1'b0;
        last_q   <= '0;
      end
      DC_SCAN_ROOT: begin
        tbl_q <= root_q;
        cnt_q <= '0;
      end
      DC_SCAN_SUB: begin
        tbl_q <= sub_q;
        cnt_q <= '0;
      end
      DC_SCAN_CHK: begin
        if (rdata_q[0]) begin
          hit_q <= rdata_q[ENTRY_W-1:1];
          cnt_q <= cnt_q + 1'b1;
        end
      end
      DC_SET_LAST: begin
        last_q <= cnt_q[IDX_W-1:0] - 1'b1;
        sub_q  <= hit_q;
      end
      DC_NEWTBL_FIRST: newtbl_q <= 1'b1;
      DC_NEWTBL_NEXT: begin
        newtbl_q <= 1'b1;
        last_q   <= last_q + 1'b1;
      end
      DC_SET_F:     f_q <= cnt_q[IDX_W-1:0];
      DC_SET_FM1:   f_q <= cnt_q[IDX_W-1:0] - 1'b1;
      DC_ST_NOFREE: status_q <= ST_NOFREE;
      DC_ST_LIMIT:  status_q <= ST_LIMIT;
      DC_ST_EMPTY:  status_q <= ST_EMPTY;
      DC_TAKE_START, DC_CLR_START: cnt_q <= '0;
      DC_TAKE_SUB: begin
        if (!bm_bit) begin
          sub_q <= cnt_q[FRAME_W-1:0];
          tbl_q <= cnt_q[FRAME_W-1:0];
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      DC_TAKE_PAGE: begin
        if (!bm_bit) begin
          page_q <= cnt_q[FRAME_W-1:0];
          tbl_q  <= cnt_q[FRAME_W-1:0];
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      DC_CLR_WR:      cnt_q <= cnt_q + 1'b1;
      DC_WR_ROOT_SUB: f_q <= '0;
      DC_FREE_ROOT: begin
        if (!bm_bit) status_q <= ST_EMPTY;
      end
      DC_DONE: begin
        out_status_q <= status_q;
        out_page_q   <= page_q;
        out_free_q   <= free_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.op       = op_q;
    st_o.newtbl   = newtbl_q;
    st_o.scan_end = !rdata_q[0] || cnt_last;
    st_o.cnt_zero = (cnt_q == '0);
    st_o.cnt_full = cnt_q[CNT_W-1];
    st_o.cnt_last = cnt_last;
    st_o.last_max = &last_q;
    st_o.f_zero   = (f_q == '0);
    st_o.free_ok  = (free_q >= (newtbl_q ? FREE_W'(2) : FREE_W'(1)));
    st_o.bm_used  = bm_bit;
    st_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign page_address_o = {out_page_q, PAGE_SHIFT'(0)};
  assign free_frames_o  = out_free_q;
endmodule
`default_nettype wire

// ----- sv/tlpt_ctrl.sv -----
// Controller state machine sequencing scans, frame searches and writes.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t st_i,
  output dp_cmd_e       cmd_o
);
  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (st_i.op)
          OP_CREATE:           state_d = st_i.free_ok ? S_TK_PAGE : S_DONE;
          OP_GROW, OP_SHRINK:  state_d = S_S1_RD;
          default:             state_d = S_FR_CHK;
        endcase
      end
      S_FR_CHK:   state_d = st_i.bm_used ? S_ZROOT : S_DONE;
      S_S1_RD:    state_d = S_S1_CHK;
      S_S1_CHK:   state_d = st_i.scan_end ? S_S1_END : S_S1_RD;
      S_S1_END: begin
        if (!st_i.cnt_zero) state_d = S_S2_START;
        else state_d = (st_i.op == OP_GROW) ? S_CHKFREE : S_DONE;
      end
      S_S2_START: state_d = S_S2_RD;
      S_S2_RD:    state_d = S_S2_CHK;
      S_S2_CHK:   state_d = st_i.scan_end ? S_S2_END : S_S2_RD;
      S_S2_END: begin
        if (st_i.op == OP_GROW) begin
          state_d = (st_i.cnt_full && st_i.last_max) ? S_DONE : S_CHKFREE;
        end else begin
          state_d = st_i.cnt_zero ? S_DONE : S_SH_REL;
        end
      end
      S_CHKFREE: begin
        if (!st_i.free_ok) state_d = S_DONE;
        else state_d = st_i.newtbl ? S_TK_SUB : S_TK_PAGE;
      end
      S_TK_SUB:   if (!st_i.bm_used) state_d = S_CLR_INIT;
      S_CLR_INIT: state_d = S_CLR;
      S_CLR: begin
        if (st_i.cnt_last) state_d = (st_i.op == OP_CREATE) ? S_DONE : S_G_ROOT;
      end
      S_G_ROOT:   state_d = S_G_TAKE2;
      S_G_TAKE2:  state_d = S_TK_PAGE;
      S_TK_PAGE: begin
        if (!st_i.bm_used) state_d = (st_i.op == OP_CREATE) ? S_CLR_INIT : S_WR_PAGE;
      end
      S_WR_PAGE:  state_d = S_DONE;
      S_SH_REL:   state_d = S_SH_ZERO;
      S_SH_ZERO:  state_d = st_i.f_zero ? S_SH_REL2 : S_DONE;
      S_SH_REL2:  state_d = S_ZROOT;
      S_ZROOT:    state_d = S_DONE;
      S_DONE:     if (st_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = DC_NONE;
    case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o = DC_LOAD;
      S_DISPATCH: begin
        case (st_i.op)
          OP_CREATE:          cmd_o = st_i.free_ok ? DC_TAKE_START : DC_ST_NOFREE;
          OP_GROW, OP_SHRINK: cmd_o = DC_SCAN_ROOT;
          default:            cmd_o = DC_NONE;
        endcase
      end
      S_FR_CHK:           cmd_o = DC_FREE_ROOT;
      S_S1_RD, S_S2_RD:   cmd_o = DC_SCAN_RD;
      S_S1_CHK, S_S2_CHK: cmd_o = DC_SCAN_CHK;
      S_S1_END: begin
        if (!st_i.cnt_zero) cmd_o = DC_SET_LAST;
        else cmd_o = (st_i.op == OP_GROW) ? DC_NEWTBL_FIRST : DC_ST_EMPTY;
      end
      S_S2_START:         cmd_o = DC_SCAN_SUB;
      S_S2_END: begin
        if (st_i.op == OP_GROW) begin
          if (!st_i.cnt_full) cmd_o = DC_SET_F;
          else cmd_o = st_i.last_max ? DC_ST_LIMIT : DC_NEWTBL_NEXT;
        end else begin
          cmd_o = st_i.cnt_zero ? DC_ST_EMPTY : DC_SET_FM1;
        end
      end
      S_CHKFREE:  cmd_o = st_i.free_ok ? DC_TAKE_START : DC_ST_NOFREE;
      S_TK_SUB:   cmd_o = DC_TAKE_SUB;
      S_CLR_INIT: cmd_o = DC_CLR_START;
      S_CLR:      cmd_o = DC_CLR_WR;
      S_G_ROOT:   cmd_o = DC_WR_ROOT_SUB;
      S_G_TAKE2:  cmd_o = DC_TAKE_START;
      S_TK_PAGE:  cmd_o = DC_TAKE_PAGE;
      S_WR_PAGE:  cmd_o = DC_WR_SUB_PAGE;
      S_SH_REL:   cmd_o = DC_REL_HIT;
      S_SH_ZERO:  cmd_o = DC_ZERO_SUB_ENTRY;
      S_SH_REL2:  cmd_o = DC_REL_SUB;
      S_ZROOT:    cmd_o = DC_ZERO_ROOT_LAST;
      S_DONE:     cmd_o = st_i.out_free ? DC_DONE : DC_NONE;
      default:    cmd_o = DC_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule
`default_nettype wire

// ----- sv/two_level_page_table_grow_shrink_top.sv -----
// Top level of the two-level page table frame allocator.
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_page_table_grow_shrink_top_defines.svh"
// One operation word is taken at a time; its result word sits in an output
// register so the next word can be accepted while it waits. Run time is set
// by the single-port table memory and the bitmap walk: a table scan reads and
// checks each present entry in turn, a lowest-free-frame search tests one
// bitmap bit at a time, and clearing a new table writes all 1024 entries.
// No clearing pass runs after reset; the memory needs none.
module two_level_page_table_grow_shrink_top
  import tlpt_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  tlpt_in_if.sink    in_ch,
  tlpt_out_if.source out_ch,
  tlpt_cfg_if.sink   cfg_ch
);
  dp_cmd_e  cmd;
  dp_stat_t st;

  assign cfg_ch.ready = 1'b1;

  tlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tlpt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .operation_i    (in_ch.operation),
    .root_address_i (in_ch.root_address),
    .cfg_we_i       (cfg_ch.valid),
    .cfg_data_i     (cfg_ch.data),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .status_o       (out_ch.status),
    .page_address_o (out_ch.page_address),
    .free_frames_o  (out_ch.free_frames)
  );

  `TLPT_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "input accepted while busy")
  `TLPT_ASSERT(a_done_has_room, clk_i, rst_ni, (cmd == DC_DONE) |-> st.out_free, "result overwrote a pending word")
  `TLPT_ASSERT(a_fail_no_page, clk_i, rst_ni, (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.page_address == '0), "failed op reported a page")
  `TLPT_ASSERT(a_free_bound, clk_i, rst_ni, out_ch.valid |-> (out_ch.free_frames <= FREE_W'(FRAMES)), "free count out of range")
endmodule
`default_nettype wire

// ----- test/tlpt_checker.sv -----
// Checker: predicts every result word of the frame allocator and compares it.
`timescale 1ns / 1ps
module tlpt_checker
  import tlpt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tlpt_in_if          in_ch,
  tlpt_out_if         out_ch,
  tlpt_cfg_if         cfg_ch,
  output int          fail_cnt_o,
  output int          pending_o,
  output logic [FRAMES-1:0] safe_o
);
  typedef struct {
    status_e          status;
    logic [RADDR_W-1:0] page;
    logic [FREE_W-1:0]  free;
  } result_t;

  bit [ENTRY_W-1:0] tbl [FRAMES*ENTRIES];
  bit               used [FRAMES];
  logic [FRAMES-1:0] cleared;
  int unsigned      free_cnt;
  int unsigned      total_frames;
  result_t          results_q [$];

  assign pending_o = results_q.size();

  function automatic int unsigned frame_lim();
    return (total_frames < FRAMES) ? total_frames : FRAMES;
  endfunction

  function automatic int unsigned free_avail(int unsigned enough);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < frame_lim() && n < enough; i++)
      if (!used[i]) n++;
    return n;
  endfunction

  function automatic int unsigned take_frame();
    int unsigned i;
    for (i = 0; i < frame_lim(); i++)
      if (!used[i]) break;
    if (i >= frame_lim()) return 0;
    used[i] = 1'b1;
    if (free_cnt > 0) free_cnt--;
    return i;
  endfunction

  function automatic void release_frame(int unsigned f, output bit ok);
    ok = 1'b0;
    if (f < FRAMES && used[f]) begin
      used[f] = 1'b0;
      if (free_cnt < FRAMES) free_cnt++;
      ok = 1'b1;
    end
  endfunction

  function automatic void wipe_table(int unsigned f);
    for (int unsigned i = 0; i < ENTRIES; i++) tbl[f*ENTRIES+i] = '0;
    cleared[f] = 1'b1;
  endfunction

  function automatic int unsigned first_hole(int unsigned t);
    int unsigned i;
    for (i = 0; i < ENTRIES; i++)
      if (!tbl[t*ENTRIES+i][0]) break;
    return i;
  endfunction

  // a root is usable when it and its last second-level table were cleared
  function automatic bit root_ok(int unsigned f);
    int unsigned t, s;
    if (!cleared[f]) return 1'b0;
    t = first_hole(f);
    if (t == 0) return 1'b1;
    s = tbl[f*ENTRIES+t-1][ENTRY_W-1:1];
    return cleared[s];
  endfunction

  function automatic void update_safe();
    for (int unsigned f = 0; f < FRAMES; f++) safe_o[f] = root_ok(f);
  endfunction

  function automatic result_t run_op(op_e op, logic [RADDR_W-1:0] ra);
    result_t     r;
    int unsigned root, t, last, sub, f, need, pg, idx;
    bit          new_tbl, ok;
    root = ra[RADDR_W-1:PAGE_SHIFT];
    r.status = ST_OK;
    pg = 0;
    case (op)
      OP_CREATE: begin
        if (free_avail(1) < 1) r.status = ST_NOFREE;
        else begin
          pg = take_frame();
          wipe_table(pg);
        end
      end
      OP_GROW: begin
        t = first_hole(root);
        need = 1; last = 0; sub = 0; f = 0; new_tbl = 1'b0;
        if (t == 0) begin
          new_tbl = 1'b1;
          need = 2;
        end else begin
          last = t - 1;
          sub = tbl[root*ENTRIES+last][ENTRY_W-1:1];
          f = first_hole(sub);
          if (f >= ENTRIES) begin
            if (last == ENTRIES - 1) r.status = ST_LIMIT;
            new_tbl = 1'b1;
            need = 2;
            last++;
          end
        end
        if (r.status == ST_OK && free_avail(need) < need) r.status = ST_NOFREE;
        if (r.status == ST_OK) begin
          if (new_tbl) begin
            sub = take_frame();
            wipe_table(sub);
            tbl[root*ENTRIES+last] = {sub[FRAME_W-1:0], 1'b1};
            f = 0;
          end
          pg = take_frame();
          tbl[sub*ENTRIES+f] = {pg[FRAME_W-1:0], 1'b1};
        end
      end
      OP_SHRINK: begin
        t = first_hole(root);
        if (t == 0) r.status = ST_EMPTY;
        else begin
          last = t - 1;
          sub = tbl[root*ENTRIES+last][ENTRY_W-1:1];
          f = first_hole(sub);
          if (f == 0) r.status = ST_EMPTY;
          else begin
            idx = sub*ENTRIES + f - 1;
            release_frame(tbl[idx][ENTRY_W-1:1], ok);
            tbl[idx] = '0;
            if (f == 1) begin
              release_frame(sub, ok);
              tbl[root*ENTRIES+last] = '0;
            end
          end
        end
      end
      default: begin
        release_frame(root, ok);
        if (ok) tbl[root*ENTRIES] = '0;
        else r.status = ST_EMPTY;
      end
    endcase
    r.page = pg[FRAME_W-1:0] << PAGE_SHIFT;
    r.free = free_cnt[FREE_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES*ENTRIES; i++) tbl[i] = '0;
      for (int i = 0; i < FRAMES; i++) used[i] = 1'b0;
      total_frames = 256;
      free_cnt = frame_lim();
      cleared = '0;
      safe_o = '0;
      fail_cnt_o = 0;
      results_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_q.size() == 0) begin
          $display("%0t: unexpected result word status=%0d page=%h free=%0d", $time,
                   out_ch.status, out_ch.page_address, out_ch.free_frames);
          fail_cnt_o++;
        end else begin
          e = results_q.pop_front();
          if (out_ch.status !== e.status || out_ch.page_address !== e.page ||
              out_ch.free_frames !== e.free) begin
            $display("%0t: mismatch expected status=%0d page=%h free=%0d, actual status=%0d page=%h free=%0d",
                     $time, e.status, e.page, e.free,
                     out_ch.status, out_ch.page_address, out_ch.free_frames);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        total_frames = cfg_ch.data;
        for (int i = 0; i < FRAMES; i++) used[i] = 1'b0;
        free_cnt = frame_lim();
      end
      if (in_ch.valid && in_ch.ready) begin
        results_q.push_back(run_op(op_e'(in_ch.operation), in_ch.root_address));
        update_safe();
      end
    end
  end
endmodule

// ----- test/tb_two_level_page_table_grow_shrink_top.sv -----
// Testbench top: stimulus, stall patterns and verdict for the frame allocator.
`timescale 1ns / 1ps
module tb_two_level_page_table_grow_shrink_top;
  import tlpt_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   burst_left;
  int   rdy_pct;
  logic [FRAMES-1:0] safe;

  tlpt_in_if  in_ch ();
  tlpt_out_if out_ch ();
  tlpt_cfg_if cfg_ch ();

  two_level_page_table_grow_shrink_top uut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tlpt_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .safe_o(safe)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #36_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver stalls: ready rate switches among 100, 60 and 15 percent
  initial begin
    out_ch.ready = 1'b0;
    rdy_pct = 100;
    forever begin
      repeat (200) begin
        @(posedge clk_i);
        out_ch.ready <= ($urandom_range(0, 99) < rdy_pct);
      end
      case ($urandom_range(0, 2))
        0: rdy_pct = 100;
        1: rdy_pct = 60;
        default: rdy_pct = 15;
      endcase
    end
  end

  task automatic send_word(op_e op, logic [RADDR_W-1:0] ra);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.root_address <= ra;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_total(logic [FREE_W-1:0] v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [RADDR_W-1:0] frame_addr(int unsigned f);
    logic [11:0] low;
    low = 12'($urandom());
    return {f[FRAME_W-1:0], low};
  endfunction

  // the root is picked once the checker has seen the previous word
  task automatic random_word();
    int unsigned pick, f;
    bit          found;
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    pick = $urandom_range(0, 99);
    found = 1'b0;
    for (int k = 0; k < 400 && !found; k++) begin
      f = $urandom_range(0, FRAMES - 1);
      found = safe[f];
    end
    @(posedge clk_i);
    if (pick < 18 || !found) send_word(OP_CREATE, 20'($urandom()));
    else if (pick < 62) send_word(OP_GROW, frame_addr(f));
    else if (pick < 87) send_word(OP_SHRINK, frame_addr(f));
    else if (pick < 95) send_word(OP_FREE, frame_addr(f));
    else send_word(OP_FREE, 20'($urandom()));
  endtask

  initial begin
    rst_ni = 1'b0;
    burst_left = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_CREATE;
    in_ch.root_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default size: grow, shrink past empty, double free, extreme addresses
    send_word(OP_CREATE, 20'h00000);
    repeat (3) send_word(OP_GROW, 20'h00FFF);
    repeat (4) send_word(OP_SHRINK, 20'h00000);
    send_word(OP_FREE, 20'h00ABC);
    send_word(OP_FREE, 20'h00000);
    send_word(OP_FREE, 20'hFFFFF);
    send_word(OP_GROW, 20'h00000);
    send_word(OP_SHRINK, 20'h00000);

    // two frames: grow runs out, create runs out
    write_total(9'd2);
    send_word(OP_CREATE, 20'h00000);
    send_word(OP_GROW, 20'h00000);
    send_word(OP_CREATE, 20'hFFFFF);
    send_word(OP_CREATE, 20'h00000);
    send_word(OP_FREE, 20'h01000);
    send_word(OP_SHRINK, 20'h00000);

    write_total(9'd0);
    send_word(OP_CREATE, 20'h00000);
    send_word(OP_FREE, 20'h00000);
    write_total(9'd1);
    send_word(OP_CREATE, 20'h00000);

    write_total(9'h1FF);
    repeat (50) random_word();
    write_total(9'($urandom_range(3, 40)));
    repeat (30) random_word();
    write_total(9'd256);
    repeat (35) random_word();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
